// ===== hdl/bpss_pkg.sv =====
// Package for the block peak / sum-of-squares meter.
// Constants, register indexes and item types; no dependencies.
package bpss_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int SAMPLE_WIDTH = 24;
  localparam int SUM_W        = 64;
  localparam int FRAME_W      = 24;
  localparam int CHAN_CFG_W   = 4;
  localparam int BITS_CFG_W   = 5;
  localparam int CFG_DATA_W   = 5;
  localparam int SQ_W         = 2 * SAMPLE_WIDTH;
  localparam int IN_DATA_W    = 24;
  localparam int IN_USER_W    = 4;
  localparam int OUT_DATA_W   = 112;
  localparam int OUT_USER_W   = 3;

  localparam logic [FRAME_W-1:0]      FRAME_MAX     = '1;
  localparam logic [SAMPLE_WIDTH-1:0] FULL_SCALE    = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [CHAN_CFG_W-1:0]   CHANNELS_RST  = 4'd2;
  localparam logic [BITS_CFG_W-1:0]   BITS_RST      = 5'd16;

  // configuration register indexes
  typedef enum logic {
    REG_CHANNELS_IN_USE = 1'b0,
    REG_SAMPLE_BITS     = 1'b1
  } reg_index_t;

  // whole-byte sample width after clamping
  typedef enum logic [1:0] {
    WIDTH_8  = 2'd1,
    WIDTH_16 = 2'd2,
    WIDTH_24 = 2'd3
  } width_code_t;

  typedef struct packed {
    logic                    block_start;
    logic [CH_W-1:0]         channel;
    logic [SAMPLE_WIDTH-1:0] pcm_word;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]      frames_done;
    logic [SUM_W-1:0]        sum_squares;
    logic [SAMPLE_WIDTH-1:0] peak;
  } result_t;

endpackage

// ===== hdl/block_peak_sum_squares.sv =====
// Block peak and sum-of-squares meter, top level.
// Pipeline: 2 register stages, the input register s1 and the result register;
// a request accepted into s1 moves on to the result register and m_tvalid when the output is not stalled.
// Throughput: one request per cycle while m_tready does not stall the output;
// the input register and the result register each hold one request, and the
// per-channel read-modify-write of the peak and sum stores happens between them.
// Reset (rst, synchronous): stores and frame count clear, channels_in_use=2,
// sample_bits=16, both pipeline slots empty.
module block_peak_sum_squares
  import bpss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [23:0] pcm_word
  input  logic [IN_USER_W-1:0]  s_tuser,   // [2:0] channel, [3] block_start
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [23:0] peak, [87:24] sum_squares,
                                           // [111:88] frames_done
  output logic [OUT_USER_W-1:0] m_tuser    // [2:0] out_channel
);

  // configuration
  logic [CHAN_CFG_W-1:0] channels_in_use;
  logic [BITS_CFG_W-1:0] sample_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= CHANNELS_RST;
      sample_bits     <= BITS_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_CHANNELS_IN_USE: channels_in_use <= cfg_data[CHAN_CFG_W-1:0];
        REG_SAMPLE_BITS:     sample_bits     <= cfg_data[BITS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp byte count to 1..3; channel count to 1..MAX_CHANNELS, kept as
  // the index of the last channel of a frame.
  width_code_t   width_code;
  logic [CH_W-1:0] last_channel;

  always_comb begin
    if (sample_bits[4:3] == 2'd0) width_code = WIDTH_8;
    else                          width_code = width_code_t'(sample_bits[4:3]);

    if (channels_in_use == '0)
      last_channel = '0;
    else if (channels_in_use > CHAN_CFG_W'(MAX_CHANNELS))
      last_channel = CH_W'(MAX_CHANNELS - 1);
    else
      last_channel = CH_W'(channels_in_use - CHAN_CFG_W'(1));
  end

  // pipeline control: result register advances when empty or drained
  logic     s1_valid;
  in_item_t s1;
  logic     advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1.pcm_word    <= s_tdata[SAMPLE_WIDTH-1:0];
      s1.channel     <= s_tuser[CH_W-1:0];
      s1.block_start <= s_tuser[CH_W];
    end
  end

  // Left-align the sample so its sign sits in the top bit; bits above
  // the effective width fall off. Magnitude of the most negative value
  // wraps to exactly full scale.
  logic [SAMPLE_WIDTH-1:0] aligned;
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [SQ_W-1:0]         sq;

  always_comb begin
    unique case (width_code)
      WIDTH_8:  aligned = {s1.pcm_word[7:0], 16'd0};
      WIDTH_16: aligned = {s1.pcm_word[15:0], 8'd0};
      WIDTH_24: aligned = s1.pcm_word;
      default:  aligned = s1.pcm_word;
    endcase
    mag = aligned[SAMPLE_WIDTH-1] ? (~aligned + SAMPLE_WIDTH'(1)) : aligned;
    sq  = mag * mag;
  end

  // per-channel stores
  logic [SAMPLE_WIDTH-1:0] peak_store       [MAX_CHANNELS];
  logic [SUM_W-1:0]        square_sum_store [MAX_CHANNELS];
  logic [FRAME_W-1:0]      frame_count;

  // block start zeroes the base before this sample is folded in
  logic [SAMPLE_WIDTH-1:0] peak_base, peak_next;
  logic [SUM_W-1:0]        sum_base, sum_next;
  logic [SUM_W:0]          sum_wide;
  logic [FRAME_W-1:0]      frame_base, frame_count_next;

  always_comb begin
    peak_base  = s1.block_start ? '0 : peak_store[s1.channel];
    sum_base   = s1.block_start ? '0 : square_sum_store[s1.channel];
    frame_base = s1.block_start ? '0 : frame_count;

    peak_next = (mag > peak_base) ? mag : peak_base;
    sum_wide  = {1'b0, sum_base} + (SUM_W+1)'(sq);
    sum_next  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    if (s1.channel == last_channel && frame_base != FRAME_MAX)
      frame_count_next = frame_base + FRAME_W'(1);
    else
      frame_count_next = frame_base;
  end

  logic take;
  assign take = s1_valid && advance;

  // the addressed channel takes its new figures; on block start the others clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        peak_store[i]       <= '0;
        square_sum_store[i] <= '0;
      end
      frame_count <= '0;
    end else if (take) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        if (CH_W'(i) == s1.channel) begin
          peak_store[i]       <= peak_next;
          square_sum_store[i] <= sum_next;
        end else if (s1.block_start) begin
          peak_store[i]       <= '0;
          square_sum_store[i] <= '0;
        end
      end
      frame_count <= frame_count_next;
    end
  end

  // result register
  result_t         res;
  logic [CH_W-1:0] res_channel;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.peak        <= peak_next;
      res.sum_squares <= sum_next;
      res.frames_done <= frame_count_next;
      res_channel     <= s1.channel;
    end
  end

  assign m_tdata = res;
  assign m_tuser = res_channel;

`ifndef SYNTHESIS
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input stalled with empty input register");

  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.peak <= FULL_SCALE)
    else $error("peak above full scale");

  a_start_count: assert property (@(posedge clk) disable iff (rst)
    take && s1.block_start |=> res.frames_done <= FRAME_W'(1))
    else $error("frame count not cleared by block start");
`endif

endmodule
